[src/eod_pkg.sv]
// Shared types and constants for the Easter offset date block.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package eod_pkg;

    // Payload field types of the two channels.
    typedef logic        [13:0] t_year;
    typedef logic signed [6:0]  t_off;
    typedef logic        [4:0]  t_day;
    typedef logic        [2:0]  t_emon;
    typedef logic        [3:0]  t_mon;

    // Century (year / 100) and year / 19, both taken in the front stage.
    typedef logic [7:0] t_cent;
    typedef logic [9:0] t_q19;

    // One queued query: the raw fields plus the two quotients.
    typedef struct packed {
        t_year year;
        t_off  day_offset;
        t_cent cent;
        t_q19  q19;
    } t_entry;

    // Queue depth and pointer width.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    // Reciprocal multipliers for division by constants: x / d = (x * R) >> S.
    localparam int unsigned RECIP_100 = 5243;
    localparam int unsigned SHIFT_100 = 19;
    localparam int unsigned RECIP_19  = 55189;
    localparam int unsigned SHIFT_19  = 20;
    localparam int unsigned RECIP_25  = 41;
    localparam int unsigned SHIFT_25  = 10;
    localparam int unsigned RECIP_3   = 171;
    localparam int unsigned SHIFT_3   = 9;
    localparam int unsigned RECIP_30  = 547;
    localparam int unsigned SHIFT_30  = 14;
    localparam int unsigned RECIP_7   = 147;
    localparam int unsigned SHIFT_7   = 10;

    // Computus constants.
    localparam int unsigned MOON_DIV    = 451;
    localparam int unsigned BASE_OFFSET = 114;

    // Month numbers of Easter.
    localparam t_emon MONTH_MAR = 3'd3;
    localparam t_emon MONTH_APR = 3'd4;

    // Back-end sequencer steps.
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MOD,
        BK_GQ,
        BK_HSUM,
        BK_HMOD,
        BK_LMOD,
        BK_BASE,
        BK_ORD,
        BK_MON
    } t_back_state;

endpackage

`default_nettype wire

[src/eod_req_if.sv]
// Query channel: valid/ready handshake carrying a year and a day offset.
// Depends on eod_pkg for the field types.
`default_nettype none

interface eod_req_if;
    logic               valid;
    logic               ready;
    eod_pkg::t_year     year;
    eod_pkg::t_off      day_offset;

    modport source (output valid, output year, output day_offset, input ready);
    modport sink   (input valid, input year, input day_offset, output ready);
endinterface

`default_nettype wire

[src/eod_rsp_if.sv]
// Result channel: valid/ready handshake carrying Easter and the shifted date.
// Depends on eod_pkg for the field types.
`default_nettype none

interface eod_rsp_if;
    logic               valid;
    logic               ready;
    eod_pkg::t_day      easter_day_of_month;
    eod_pkg::t_emon     easter_month_number;
    eod_pkg::t_day      shifted_day;
    eod_pkg::t_mon      shifted_month;

    modport source (output valid, output easter_day_of_month, output easter_month_number,
                    output shifted_day, output shifted_month, input ready);
    modport sink   (input valid, input easter_day_of_month, input easter_month_number,
                    input shifted_day, input shifted_month, output ready);
endinterface

`default_nettype wire

[src/easter_offset_date_top.sv]
// Easter offset date: Gregorian Easter Sunday and a date a signed offset away.
// The back-end sequencer takes one query at a time, one computus step per cycle while
// its output register has room; a 2-entry queue and the front register buffer input.
// Reset (synchronous, active low) empties the front stage, queue and output register.
`default_nettype none

module easter_offset_date_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    eod_req_if.sink     i_req,
    eod_rsp_if.source   o_rsp
);
    import eod_pkg::*;

    logic   w_fq_valid;
    logic   w_fq_ready;
    t_entry w_fq_entry;
    logic   w_qb_valid;
    logic   w_qb_pop;
    t_entry w_qb_entry;

    // Front stage: takes query beats and computes the quotients.
    eod_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_q_ready (w_fq_ready),
        .o_q_valid (w_fq_valid),
        .o_q_entry (w_fq_entry)
    );

    // Decoupling queue.
    eod_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_entry (w_fq_entry),
        .o_pop_valid  (w_qb_valid),
        .i_pop        (w_qb_pop),
        .o_pop_entry  (w_qb_entry)
    );

    // Back end: computus, date shift and output register.
    eod_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .o_q_pop   (w_qb_pop),
        .i_q_entry (w_qb_entry),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

[src/eod_front.sv]
// Front stage: accepts query beats and registers year / 100 and year / 19.
// Depends on eod_pkg and eod_req_if.
`default_nettype none

module eod_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    eod_req_if.sink             i_req,
    input  wire                 i_q_ready,
    output logic                o_q_valid,
    output eod_pkg::t_entry     o_q_entry
);
    import eod_pkg::*;

    logic        r_valid;
    t_entry      r_entry;
    t_entry      n_entry;
    logic [26:0] w_prod100;
    logic [29:0] w_prod19;

    // The stage frees up when empty or when the queue takes its beat.
    assign i_req.ready = !r_valid || i_q_ready;

    // Reciprocal multiplications for the two quotients.
    always_comb begin
        w_prod100         = 27'(i_req.year) * 27'(RECIP_100);
        w_prod19          = 30'(i_req.year) * 30'(RECIP_19);
        n_entry.year       = i_req.year;
        n_entry.day_offset = i_req.day_offset;
        n_entry.cent       = w_prod100[SHIFT_100 +: 8];
        n_entry.q19        = w_prod19[SHIFT_19 +: 10];
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_entry <= n_entry;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_entry = r_entry;

endmodule

`default_nettype wire

[src/eod_queue.sv]
// Short FIFO that decouples the front stage from the back-end sequencer.
// Depends on eod_pkg for the entry type and depth.
`default_nettype none

module eod_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  eod_pkg::t_entry     i_push_entry,
    output logic                o_pop_valid,
    input  wire                 i_pop,
    output eod_pkg::t_entry     o_pop_entry
);
    import eod_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

[src/eod_back.sv]
// Back-end sequencer: runs the computus and the date shift one step a cycle unless
// the output register holding the result is full. Depends on eod_pkg, eod_rsp_if.
`default_nettype none

module eod_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    output logic                o_q_pop,
    input  eod_pkg::t_entry     i_q_entry,
    eod_rsp_if.source           o_rsp
);
    import eod_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    // Working registers.
    t_entry      r_ent;
    logic [4:0]  r_a;
    logic [6:0]  r_c;
    logic [3:0]  r_f;
    logic [6:0]  r_g;
    logic        r_leap;
    logic [9:0]  r_hx;
    logic [4:0]  r_h;
    logic [2:0]  r_l;
    t_day        r_eday;
    t_emon       r_emon;
    logic [7:0]  r_ord;

    // Output register.
    logic        r_out_valid;
    t_day        r_out_eday;
    t_emon       r_out_emon;
    t_day        r_out_sday;
    t_mon        r_out_smon;

    // Next values.
    logic [4:0]  n_a;
    logic [6:0]  n_c;
    logic [3:0]  n_f;
    logic [6:0]  n_g;
    logic        n_leap;
    logic [9:0]  n_hx;
    logic [4:0]  n_h;
    logic [2:0]  n_l;
    t_day        n_eday;
    t_emon       n_emon;
    logic [7:0]  n_ord;
    t_day        n_sday;
    t_mon        n_smon;
    logic        n_load_out;

    // Intermediate wires.
    logic [13:0] w_a_full;
    logic [13:0] w_c_full;
    logic [7:0]  w_b8;
    logic [13:0] w_f_prod;
    logic [7:0]  w_gx;
    logic [15:0] w_g_prod;
    logic [19:0] w_h_prod;
    logic [4:0]  w_h_quo;
    logic [9:0]  w_h_full;
    logic [6:0]  w_lx;
    logic [14:0] w_l_prod;
    logic [3:0]  w_l_quo;
    logic [6:0]  w_l_full;
    logic [8:0]  w_mx;
    logic [7:0]  w_base;
    logic [7:0]  w_cum;
    logic signed [8:0] w_ord;
    logic [7:0]  w_feb_end;
    logic [7:0]  w_mar_end;
    logic [7:0]  w_apr_end;
    logic [7:0]  w_may_end;

    // Computus arithmetic, one group per sequencer step.
    always_comb begin
        // Remainders of year by 19 and by 100, and (century + 8) / 25.
        w_a_full = r_ent.year - 14'(r_ent.q19) * 14'd19;
        w_c_full = r_ent.year - 14'(r_ent.cent) * 14'd100;
        n_a      = w_a_full[4:0];
        n_c      = w_c_full[6:0];
        w_b8     = r_ent.cent + 8'd8;
        w_f_prod = 14'(w_b8) * 14'(RECIP_25);
        n_f      = w_f_prod[SHIFT_25 +: 4];

        // (century - f + 1) / 3 and the leap-year flag.
        w_gx     = r_ent.cent - 8'(r_f) + 8'd1;
        w_g_prod = 16'(w_gx) * 16'(RECIP_3);
        n_g      = w_g_prod[SHIFT_3 +: 7];
        n_leap   = (r_ent.year[1:0] == 2'b00) &&
                   ((r_c != 7'd0) || (r_ent.cent[1:0] == 2'b00));

        // Epact sum before its reduction modulo 30.
        n_hx = 10'(r_a) * 10'd19 + 10'(r_ent.cent) - 10'(r_ent.cent[7:2])
             - 10'(r_g) + 10'd15;

        // h = sum mod 30.
        w_h_prod = 20'(r_hx) * 20'(RECIP_30);
        w_h_quo  = w_h_prod[SHIFT_30 +: 5];
        w_h_full = r_hx - 10'(w_h_quo) * 10'd30;
        n_h      = w_h_full[4:0];

        // l = weekday correction mod 7.
        w_lx     = 7'd32 + 7'd2 * 7'(r_ent.cent[1:0]) + 7'd2 * 7'(r_c[6:2])
                 - 7'(r_h) - 7'(r_c[1:0]);
        w_l_prod = 15'(w_lx) * 15'(RECIP_7);
        w_l_quo  = w_l_prod[SHIFT_7 +: 4];
        w_l_full = w_lx - 7'(w_l_quo) * 7'd7;
        n_l      = w_l_full[2:0];

        // The quotient by 451 is zero or one; then split the sum into month and day.
        w_mx   = 9'(r_a) + 9'(r_h) * 9'd11 + 9'(r_l) * 9'd22;
        w_base = 8'(r_h) + 8'(r_l) + 8'(BASE_OFFSET)
               - ((w_mx >= 9'(MOON_DIV)) ? 8'd7 : 8'd0);
        if (w_base >= 8'd124) begin
            n_emon = MONTH_APR;
            n_eday = 5'(w_base - 8'd123);
        end else begin
            n_emon = MONTH_MAR;
            n_eday = 5'(w_base - 8'd92);
        end

        // Day of year of Easter plus the offset, never below the first day.
        w_cum = (r_emon == MONTH_APR) ? (8'd90 + 8'(r_leap)) : (8'd59 + 8'(r_leap));
        w_ord = $signed({4'b0000, r_eday}) + $signed({1'b0, w_cum})
              + $signed({{2{r_ent.day_offset[6]}}, r_ent.day_offset});
        if (w_ord < 9'sd1) begin
            n_ord = 8'd1;
        end else begin
            n_ord = w_ord[7:0];
        end

        // Split the day of year back into month and day.
        w_feb_end = 8'd59  + 8'(r_leap);
        w_mar_end = 8'd90  + 8'(r_leap);
        w_apr_end = 8'd120 + 8'(r_leap);
        w_may_end = 8'd151 + 8'(r_leap);
        priority if (r_ord <= 8'd31) begin
            n_smon = 4'd1;
            n_sday = 5'(r_ord);
        end else if (r_ord <= w_feb_end) begin
            n_smon = 4'd2;
            n_sday = 5'(r_ord - 8'd31);
        end else if (r_ord <= w_mar_end) begin
            n_smon = 4'd3;
            n_sday = 5'(r_ord - w_feb_end);
        end else if (r_ord <= w_apr_end) begin
            n_smon = 4'd4;
            n_sday = 5'(r_ord - w_mar_end);
        end else if (r_ord <= w_may_end) begin
            n_smon = 4'd5;
            n_sday = 5'(r_ord - w_apr_end);
        end else begin
            n_smon = 4'd6;
            n_sday = 5'(r_ord - w_may_end);
        end
    end

    // Sequencer next state and queue pop.
    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        n_load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = BK_MOD;
                end
            end
            BK_MOD:  n_state = BK_GQ;
            BK_GQ:   n_state = BK_HSUM;
            BK_HSUM: n_state = BK_HMOD;
            BK_HMOD: n_state = BK_LMOD;
            BK_LMOD: n_state = BK_BASE;
            BK_BASE: n_state = BK_ORD;
            BK_ORD:  n_state = BK_MON;
            BK_MON: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_load_out = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers, each loaded in its own step.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_entry;
        end
        if (r_state == BK_MOD) begin
            r_a <= n_a;
            r_c <= n_c;
            r_f <= n_f;
        end
        if (r_state == BK_GQ) begin
            r_g    <= n_g;
            r_leap <= n_leap;
        end
        if (r_state == BK_HSUM) begin
            r_hx <= n_hx;
        end
        if (r_state == BK_HMOD) begin
            r_h <= n_h;
        end
        if (r_state == BK_LMOD) begin
            r_l <= n_l;
        end
        if (r_state == BK_BASE) begin
            r_eday <= n_eday;
            r_emon <= n_emon;
        end
        if (r_state == BK_ORD) begin
            r_ord <= n_ord;
        end
    end

    // Output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output beat payload.
    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_out_eday <= r_eday;
            r_out_emon <= r_emon;
            r_out_sday <= n_sday;
            r_out_smon <= n_smon;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.easter_day_of_month = r_out_eday;
    assign o_rsp.easter_month_number = r_out_emon;
    assign o_rsp.shifted_day         = r_out_sday;
    assign o_rsp.shifted_month       = r_out_smon;

endmodule

`default_nettype wire

[dv/eod_date_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the Easter offset date block: watches both channels, computes
// the expected dates of each query beat and checks every result beat in order.
// Depends on eod_pkg for the field types.

module eod_date_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  eod_pkg::t_year i_year,
    input  eod_pkg::t_off  i_day_offset,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  eod_pkg::t_day  i_paschal_day,
    input  eod_pkg::t_emon i_paschal_month,
    input  eod_pkg::t_day  i_shifted_day,
    input  eod_pkg::t_mon  i_shifted_month,
    output int             o_fail_count,
    output int             o_pending
);
    import eod_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // One expected result, with the query kept for the report.
    typedef struct packed {
        t_year year;
        t_off  day_offset;
        t_day  paschal_day;
        t_emon paschal_month;
        t_day  shifted_day;
        t_mon  shifted_month;
    } t_date_expect;

    t_date_expect expected_dates[$];
    t_date_expect head;
    int           mismatch_count = 0;

    // Month length, with February following the Gregorian leap-year rule.
    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input int unsigned mon);
        int unsigned n;
        case (mon)
            2: begin
                n = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                n = 30;
            end
            default: begin
                n = 31;
            end
        endcase
        return n;
    endfunction

    // Easter Sunday by the anonymous Gregorian computus, then the date that
    // lies the signed offset away, walked through the month lengths.
    function automatic t_date_expect predict_easter_dates(input t_year yr,
                                                          input t_off off);
        t_date_expect res;
        int unsigned  y, gold, cent, yc, cq4, cr4, fcorr, gcorr;
        int unsigned  epact, yq4, yr4, wday, corr, total;
        int unsigned  eday, emon, rest, smon, mon;
        int           ordinal;
        y     = yr;
        gold  = y % 19;
        cent  = y / 100;
        yc    = y % 100;
        cq4   = cent / 4;
        cr4   = cent % 4;
        fcorr = (cent + 8) / 25;
        gcorr = (cent - fcorr + 1) / 3;
        epact = (19 * gold + cent - cq4 - gcorr + 15) % 30;
        yq4   = yc / 4;
        yr4   = yc % 4;
        wday  = (32 + 2 * cr4 + 2 * yq4 - epact - yr4) % 7;
        corr  = (gold + 11 * epact + 22 * wday) / MOON_DIV;
        total = epact + wday - 7 * corr + BASE_OFFSET;
        eday  = total % 31 + 1;
        emon  = total / 31;

        // Day of the year of Easter, moved by the offset.
        ordinal = int'(eday);
        for (mon = 1; mon < emon && mon <= 12; mon++)
            ordinal += int'(days_in_month(y, mon));
        ordinal += int'(off);
        if (ordinal < 1)
            ordinal = 1;

        // Back to month and day.
        rest = ordinal;
        smon = 1;
        while (smon < 12 && rest > days_in_month(y, smon)) begin
            rest -= days_in_month(y, smon);
            smon++;
        end

        res.year          = yr;
        res.day_offset    = off;
        res.paschal_day   = t_day'(eday);
        res.paschal_month = t_emon'(emon);
        res.shifted_day   = t_day'(rest);
        res.shifted_month = t_mon'(smon);
        return res;
    endfunction

    // Result beats are checked before the query beat of the same edge is
    // queued, so a result can never match a query accepted with it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_dates.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_dates.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display(
                            "%0t: result beat %0d/%0d shifted %0d/%0d, none pending",
                            $time, i_paschal_day, i_paschal_month,
                            i_shifted_day, i_shifted_month);
                    mismatch_count++;
                end else begin
                    head = expected_dates.pop_front();
                    if (head.paschal_day !== i_paschal_day
                            || head.paschal_month !== i_paschal_month
                            || head.shifted_day !== i_shifted_day
                            || head.shifted_month !== i_shifted_month) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display(
                                "%0t: year %0d off %0d exp %0d/%0d %0d/%0d got %0d/%0d %0d/%0d",
                                $time, head.year, head.day_offset,
                                head.paschal_day, head.paschal_month,
                                head.shifted_day, head.shifted_month,
                                i_paschal_day, i_paschal_month,
                                i_shifted_day, i_shifted_month);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_dates.push_back(predict_easter_dates(i_year, i_day_offset));
            o_pending <= expected_dates.size();
        end
        o_fail_count <= mismatch_count;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the Easter offset date testbench: clock, reset, query and result-side
// stimulus through the idling phases, and the verdict.
// Depends on eod_pkg, both channel interfaces, the block and eod_date_checker.

module tb_top;
    import eod_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 30;
    localparam int RANDOM_PER_PHASE = 260;
    localparam int LONG_HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   rsp_stall_pct = 0;
    int   rsp_hold_left = 0;
    int   cycle_count   = 0;
    int   fail_count;
    int   pending_count;

    eod_req_if req_ch();
    eod_rsp_if rsp_ch();

    easter_offset_date_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    eod_date_checker u_date_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_ch.valid),
        .i_req_ready     (req_ch.ready),
        .i_year          (req_ch.year),
        .i_day_offset    (req_ch.day_offset),
        .i_rsp_valid     (rsp_ch.valid),
        .i_rsp_ready     (rsp_ch.ready),
        .i_paschal_day   (rsp_ch.easter_day_of_month),
        .i_paschal_month (rsp_ch.easter_month_number),
        .i_shifted_day   (rsp_ch.shifted_day),
        .i_shifted_month (rsp_ch.shifted_month),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run guard.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("easter_offset_date_top regression: fail");
            $finish;
        end
    end

    // Result side: a long hold-off when one is requested, otherwise random stalls.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Offer one query beat, after random idle cycles, and wait until it is taken.
    task automatic send_query(input int yr, input int off);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.year       <= t_year'(yr);
        req_ch.day_offset <= t_off'(off);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Mostly real Gregorian years, some anywhere in the 14-bit range,
    // and any offset.
    task automatic send_random_queries(input int count);
        int sel;
        int yr;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 80)
                yr = $urandom_range(1583, 9999);
            else if (sel < 92)
                yr = $urandom_range(0, 16383);
            else
                yr = $urandom_range(0, 1582);
            send_query(yr, int'($urandom_range(127)) - 64);
        end
    endtask

    // The pending count is registered after the handshake, hence the first wait.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.year       = '0;
        req_ch.day_offset = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Range ends, the earliest and latest Easter dates, century leap rules
        // and offsets reaching into January and June.
        send_query(1583, 0);
        send_query(9999, 0);
        send_query(0, 63);
        send_query(16383, -64);
        send_query(1818, -64);
        send_query(2285, 63);
        send_query(1943, 63);
        send_query(2038, -64);
        send_query(2000, -64);
        send_query(1900, -64);
        send_query(2400, -50);
        send_query(2100, -45);
        send_query(1954, 0);
        send_query(1981, 0);
        send_query(2008, -64);
        send_query(2024, -1);
        send_query(2024, 1);
        send_query(8191, -1);
        send_query(4096, -32);
        send_query(1600, 31);

        // Random queries under each idling pattern.
        send_random_queries(RANDOM_PER_PHASE);
        send_idle_pct = 58;
        send_random_queries(RANDOM_PER_PHASE);

        // Sender pauses until every result is back.
        req_ch.valid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        rsp_stall_pct = 58;
        send_random_queries(RANDOM_PER_PHASE);
        send_idle_pct = 6;
        rsp_stall_pct = 6;
        send_random_queries(RANDOM_PER_PHASE);

        // Long result-side hold-off while queries keep coming, to back up the block.
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        rsp_hold_left = LONG_HOLD_CYCLES;
        send_random_queries(40);

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("easter_offset_date_top regression: pass");
        end else begin
            if (pending_count != 0)
                $display("%0d expected results never arrived", pending_count);
            $display("easter_offset_date_top regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
src/eod_pkg.sv
src/eod_req_if.sv
src/eod_rsp_if.sv
src/eod_front.sv
src/eod_queue.sv
src/eod_back.sv
src/easter_offset_date_top.sv
dv/eod_date_checker.sv
dv/tb_top.sv
